// ----- rtl/fcre_pkg.sv -----
// ----------------------------------------------------------------------------
// fcre_pkg
// Shared types and constants for the frame crossing rate extractor: word
// layouts of both channels, register indexes, and controller/datapath links.
// ----------------------------------------------------------------------------
package fcre_pkg;

  // Field widths of the channel words
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 12;
  localparam int AVG_W      = 20;
  localparam int SUM_W      = 32;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int FRAME_COUNT_BITS_DEF = 20;
  localparam int AVG_FRAC_BITS_DEF    = 8;

  // Frame length limits and register reset values
  localparam logic [LEN_W-1:0]           LEN_MIN      = LEN_W'(2);
  localparam logic [LEN_W-1:0]           LEN_MAX      = LEN_W'(4096);
  localparam logic [LEN_W-1:0]           LEN_RESET    = LEN_W'(1000);
  localparam logic signed [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(1000);
  localparam logic [COUNT_W-1:0]         COUNT_MAX    = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH    = CFG_IDX_W'(1);

  // Result kinds
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_AVERAGE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] zero_crossings;
    logic [COUNT_W-1:0] level_crossings;
    logic [AVG_W-1:0]   avg_zero_crossings;
    logic [AVG_W-1:0]   avg_level_crossings;
    logic               last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic div_load;  // load dividers from the stream sums
    logic div_step;  // one quotient bit per lane
    logic avg_emit;  // place the average word, clear the stream
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // output register full and held
    logic div_done;  // final quotient bit this cycle
  } dp_stat_t;

endpackage

// ----- rtl/fcre_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcre_ctrl
// Controller: takes sample words, and at end of stream sequences the divider
// load, the bit steps and the emission of the average word.
// ----------------------------------------------------------------------------
module fcre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_eos,
  input  fcre_pkg::dp_stat_t  stat,
  output logic                in_stall,
  output fcre_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Take words only while running and the output register can move
  assign in_stall = (state_r != ST_RUN) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  // Drive datapath commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.div_load = (state_r == ST_LOAD);
    cmd.div_step = (state_r == ST_DIV);
    cmd.avg_emit = (state_r == ST_EMIT) && !stat.out_busy;
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (accept && in_eos) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/fcre_dp.sv -----
// ----------------------------------------------------------------------------
// fcre_dp
// Datapath: configuration registers, crossing detectors, frame counters,
// saturating stream sums, two restoring divider lanes and the output register.
// ----------------------------------------------------------------------------
module fcre_dp #(
  parameter int FRAME_COUNT_BITS = fcre_pkg::FRAME_COUNT_BITS_DEF,
  parameter int AVG_FRAC_BITS    = fcre_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fcre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcre_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  fcre_pkg::in_word_t                  in_data,
  input  fcre_pkg::ctrl_cmd_t                 cmd,
  output fcre_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fcre_pkg::out_word_t                 out_data
);

  localparam int SW     = fcre_pkg::SAMPLE_W;
  localparam int CW     = fcre_pkg::COUNT_W;
  localparam int AW     = fcre_pkg::AVG_W;
  localparam int UW     = fcre_pkg::SUM_W;
  localparam int LW     = fcre_pkg::LEN_W;
  localparam int FW     = FRAME_COUNT_BITS;
  localparam int DVD_W  = UW + AVG_FRAC_BITS;
  localparam int REM_W  = FW + 1;
  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

  // Configuration
  logic signed [SW-1:0] thresh_r, thresh_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        len_wr;

  // Stream state
  logic signed [SW-1:0] prev_z_r, prev_z_nxt;
  logic signed [SW-1:0] prev_l_r, prev_l_nxt;
  logic [CW-1:0]        sif_r, sif_nxt;
  logic [CW-1:0]        zc_r, zc_nxt;
  logic [CW-1:0]        lc_r, lc_nxt;
  logic [UW-1:0]        zsum_r, zsum_nxt;
  logic [UW-1:0]        lsum_r, lsum_nxt;
  logic [FW-1:0]        frames_r, frames_nxt;

  // Divider lanes: lane 0 zero crossings, lane 1 level crossings
  logic [DVD_W-1:0]  dq_r [2];
  logic [DVD_W-1:0]  dq_nxt [2];
  logic [REM_W-1:0]  rem_r [2];
  logic [REM_W-1:0]  rem_nxt [2];
  logic [REM_W-1:0]  rem_sh [2];
  logic              q_bit [2];
  logic [AW-1:0]     avg [2];
  logic [STEP_W-1:0] step_r, step_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  fcre_pkg::out_word_t out_r, out_nxt;

  // Sample-path signals
  logic signed [SW-1:0] x;
  logic                 first;
  logic                 z_keep, z_cross, l_keep, l_cross;
  logic [CW-1:0]        zc_upd, lc_upd;
  logic [LW-1:0]        sif_inc;
  logic                 frame_end;
  logic [UW:0]          zsum_add, lsum_add;
  logic [UW-1:0]        zsum_sat, lsum_sat;
  logic [FW-1:0]        frames_sat;

  // Clamp frame length on write
  always_comb begin
    len_wr = cfg_wdata[LW-1:0];
    if (len_wr < fcre_pkg::LEN_MIN) begin
      len_wr = fcre_pkg::LEN_MIN;
    end else if (len_wr > fcre_pkg::LEN_MAX) begin
      len_wr = fcre_pkg::LEN_MAX;
    end
  end

  always_comb begin
    thresh_nxt = thresh_r;
    len_nxt    = len_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        fcre_pkg::REG_LEVEL_THRESHOLD: thresh_nxt = $signed(cfg_wdata[SW-1:0]);
        fcre_pkg::REG_FRAME_LENGTH:    len_nxt    = len_wr;
        default: begin
          thresh_nxt = thresh_r;
        end
      endcase
    end
  end

  // Detect crossings against zero and against the level
  assign x       = in_data.sample;
  assign first   = (sif_r == '0);
  assign z_keep  = (x != '0);
  assign z_cross = ((prev_z_r < 0) && (x > 0)) || ((prev_z_r > 0) && (x < 0));
  assign l_keep  = (x != thresh_r);
  assign l_cross = ((prev_l_r < thresh_r) && (x > thresh_r)) ||
                   ((prev_l_r > thresh_r) && (x < thresh_r));

  always_comb begin
    zc_upd = zc_r;
    lc_upd = lc_r;
    if (first) begin
      zc_upd = '0;
      lc_upd = '0;
    end else begin
      if (z_keep && z_cross && (zc_r != fcre_pkg::COUNT_MAX)) begin
        zc_upd = zc_r + CW'(1);
      end
      if (l_keep && l_cross && (lc_r != fcre_pkg::COUNT_MAX)) begin
        lc_upd = lc_r + CW'(1);
      end
    end
  end

  // Close the frame on length or end of stream
  assign sif_inc   = {1'b0, sif_r} + LW'(1);
  assign frame_end = (sif_inc >= len_r) || in_data.end_of_stream;

  // Saturate stream sums and frame count
  assign zsum_add   = {1'b0, zsum_r} + (UW+1)'(zc_upd);
  assign lsum_add   = {1'b0, lsum_r} + (UW+1)'(lc_upd);
  assign zsum_sat   = zsum_add[UW] ? '1 : zsum_add[UW-1:0];
  assign lsum_sat   = lsum_add[UW] ? '1 : lsum_add[UW-1:0];
  assign frames_sat = (frames_r == '1) ? frames_r : frames_r + FW'(1);

  // One restoring step per lane, saturated quotient
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem_r[i][FW-1:0], dq_r[i][DVD_W-1]};
      q_bit[i]  = (rem_sh[i] >= {1'b0, frames_r});
      avg[i]    = (|dq_r[i][DVD_W-1:AW]) ? '1 : dq_r[i][AW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dq_nxt[i]  = dq_r[i];
      rem_nxt[i] = rem_r[i];
    end
    step_nxt = step_r;
    if (cmd.div_load) begin
      dq_nxt[0]  = DVD_W'(zsum_r) << AVG_FRAC_BITS;
      dq_nxt[1]  = DVD_W'(lsum_r) << AVG_FRAC_BITS;
      rem_nxt[0] = '0;
      rem_nxt[1] = '0;
      step_nxt   = '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        dq_nxt[i]  = {dq_r[i][DVD_W-2:0], q_bit[i]};
        rem_nxt[i] = q_bit[i] ? (rem_sh[i] - {1'b0, frames_r}) : rem_sh[i];
      end
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // Update stream state and output register
  always_comb begin
    prev_z_nxt    = prev_z_r;
    prev_l_nxt    = prev_l_r;
    sif_nxt       = sif_r;
    zc_nxt        = zc_r;
    lc_nxt        = lc_r;
    zsum_nxt      = zsum_r;
    lsum_nxt      = lsum_r;
    frames_nxt    = frames_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.accept) begin
      if (first || z_keep) begin
        prev_z_nxt = x;
      end
      if (first || l_keep) begin
        prev_l_nxt = x;
      end
      if (frame_end) begin
        sif_nxt                     = '0;
        zc_nxt                      = '0;
        lc_nxt                      = '0;
        zsum_nxt                    = zsum_sat;
        lsum_nxt                    = lsum_sat;
        frames_nxt                  = frames_sat;
        out_valid_nxt               = 1'b1;
        out_nxt                     = '0;
        out_nxt.kind                = fcre_pkg::KIND_FRAME;
        out_nxt.zero_crossings      = zc_upd;
        out_nxt.level_crossings     = lc_upd;
      end else begin
        sif_nxt = sif_inc[CW-1:0];
        zc_nxt  = zc_upd;
        lc_nxt  = lc_upd;
      end
    end else if (cmd.avg_emit) begin
      prev_z_nxt                  = '0;
      prev_l_nxt                  = '0;
      sif_nxt                     = '0;
      zc_nxt                      = '0;
      lc_nxt                      = '0;
      zsum_nxt                    = '0;
      lsum_nxt                    = '0;
      frames_nxt                  = '0;
      out_valid_nxt               = 1'b1;
      out_nxt                     = '0;
      out_nxt.kind                = fcre_pkg::KIND_AVERAGE;
      out_nxt.avg_zero_crossings  = avg[0];
      out_nxt.avg_level_crossings = avg[1];
      out_nxt.last                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= fcre_pkg::THRESH_RESET;
      len_r       <= fcre_pkg::LEN_RESET;
      prev_z_r    <= '0;
      prev_l_r    <= '0;
      sif_r       <= '0;
      zc_r        <= '0;
      lc_r        <= '0;
      zsum_r      <= '0;
      lsum_r      <= '0;
      frames_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thresh_r    <= thresh_nxt;
      len_r       <= len_nxt;
      prev_z_r    <= prev_z_nxt;
      prev_l_r    <= prev_l_nxt;
      sif_r       <= sif_nxt;
      zc_r        <= zc_nxt;
      lc_r        <= lc_nxt;
      zsum_r      <= zsum_nxt;
      lsum_r      <= lsum_nxt;
      frames_r    <= frames_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < 2; i++) begin
      dq_r[i]  <= dq_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign stat.div_done = (step_r == STEP_LAST);
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// ----- rtl/frame_crossing_rate_extractor.sv -----
// Output: a frame word is registered at the edge that takes the frame's last
//   sample and drives the output straight from that register.
// Throughput: one sample per cycle except while output is held or averages run.
// End of stream: the two divider lanes take 32 + AVG_FRAC_BITS steps (40 by
//   default); the input stalls through the load, the steps and the emit.
// Reset: rst_n low at a clock edge clears the stream, sets both registers to 1000.
// ----------------------------------------------------------------------------
// frame_crossing_rate_extractor
// Zero-crossing and level-crossing counts per frame, then stream averages.
// ----------------------------------------------------------------------------
module frame_crossing_rate_extractor #(
  parameter int FRAME_COUNT_BITS = fcre_pkg::FRAME_COUNT_BITS_DEF,
  parameter int AVG_FRAC_BITS    = fcre_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fcre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcre_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fcre_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fcre_pkg::out_word_t             out_data
);

  fcre_pkg::ctrl_cmd_t cmd;
  fcre_pkg::dp_stat_t  stat;

  // Sequence control
  fcre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eos   (in_data.end_of_stream),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Counters, sums and dividers
  fcre_dp #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
    .AVG_FRAC_BITS    (AVG_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // End of stream word blocks intake while averages are computed
  a_eos_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.end_of_stream |=> in_stall)
    else $error("word taken right after end of stream");

  // Divider never runs while samples are taken
  a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> in_stall)
    else $error("divider step while input open");

  // Average word only appears after the input was held off
  a_avg_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.avg_emit |=> out_valid && out_data.last && $past(in_stall))
    else $error("average word without stalled input");

endmodule

// ----- sim/tb_frame_crossing_rate_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_crossing_rate_extractor
// Drives sample streams through the crossing rate extractor under random
// stalls and gaps on both channels. Each accepted sample is run through a
// local predictor of the frame counts and stream averages, and every result
// word is checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_frame_crossing_rate_extractor;
  import fcre_pkg::*;

  localparam int  CLK_HALF      = 5;
  localparam int  RESET_CYCLES  = 9;
  localparam int  SETTLE_CYCLES = 60;
  localparam int  RANDOM_ITEMS  = 1200;
  localparam int  LIMIT_CYCLES  = 1000000;
  localparam longint unsigned SUM_SAT   = 64'hFFFF_FFFF;
  localparam longint unsigned FRAME_SAT = (64'd1 << FRAME_COUNT_BITS_DEF) - 1;
  localparam longint unsigned AVG_SAT   = (64'd1 << AVG_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;

  frame_crossing_rate_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Words waiting to be sent and results waiting to be seen
  in_word_t  sample_words[$];
  out_word_t crossing_words_due[$];

  int  n_errors = 0;
  int  cycle_cnt = 0;
  bit  in_idle_on = 1'b0;
  bit  out_idle_on = 1'b0;

  // Predictor copy of the registers and the stream state
  logic signed [SAMPLE_W-1:0] thresh_q = THRESH_RESET;
  logic [LEN_W-1:0]           len_q = LEN_RESET;
  int                         prev_zero = 0;
  int                         prev_level = 0;
  int unsigned                in_frame = 0;
  int unsigned                zero_cnt = 0;
  int unsigned                level_cnt = 0;
  longint unsigned            zero_sum = 0;
  longint unsigned            level_sum = 0;
  longint unsigned            frames_done = 0;

  // Driver and monitor scratch
  int        in_gap = 0;
  int        out_gap = 0;
  logic      drv_valid;
  in_word_t  drv_word;
  logic      nxt_stall;
  out_word_t want;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic bit crossed(int p, int c, int t);
    return (p < t && c > t) || (p > t && c < t);
  endfunction

  function automatic longint unsigned mean_fixed(longint unsigned sum,
                                                 longint unsigned frames);
    longint unsigned q;
    if (frames == 0) return 0;
    q = (sum << AVG_FRAC_BITS_DEF) / frames;
    return (q > AVG_SAT) ? AVG_SAT : q;
  endfunction

  // Advance the frame state by one sample and queue the words it produces
  task automatic count_crossings(in_word_t w);
    int          x;
    int          t;
    int unsigned lim;
    out_word_t   r;
    x = $signed(w.sample);
    t = thresh_q;
    lim = len_q;
    if (lim < LEN_MIN) lim = LEN_MIN;
    if (lim > LEN_MAX) lim = LEN_MAX;

    if (in_frame == 0) begin
      prev_zero = x;
      prev_level = x;
      zero_cnt = 0;
      level_cnt = 0;
    end else begin
      if (x != 0) begin
        if (crossed(prev_zero, x, 0) && zero_cnt < COUNT_MAX) zero_cnt++;
        prev_zero = x;
      end
      if (x != t) begin
        if (crossed(prev_level, x, t) && level_cnt < COUNT_MAX) level_cnt++;
        prev_level = x;
      end
    end
    in_frame++;

    // Close the frame on length or end of stream
    if (in_frame >= lim || w.end_of_stream) begin
      r = '0;
      r.kind = KIND_FRAME;
      r.zero_crossings = COUNT_W'(zero_cnt);
      r.level_crossings = COUNT_W'(level_cnt);
      crossing_words_due = {crossing_words_due, r};
      zero_sum = (zero_sum + zero_cnt > SUM_SAT) ? SUM_SAT : zero_sum + zero_cnt;
      level_sum = (level_sum + level_cnt > SUM_SAT) ? SUM_SAT : level_sum + level_cnt;
      if (frames_done < FRAME_SAT) frames_done++;
      in_frame = 0;
      zero_cnt = 0;
      level_cnt = 0;
    end

    // Emit the stream averages and start a fresh stream
    if (w.end_of_stream) begin
      r = '0;
      r.kind = KIND_AVERAGE;
      r.avg_zero_crossings = AVG_W'(mean_fixed(zero_sum, frames_done));
      r.avg_level_crossings = AVG_W'(mean_fixed(level_sum, frames_done));
      r.last = 1'b1;
      crossing_words_due = {crossing_words_due, r};
      prev_zero = 0;
      prev_level = 0;
      in_frame = 0;
      zero_cnt = 0;
      level_cnt = 0;
      zero_sum = 0;
      level_sum = 0;
      frames_done = 0;
    end
  endtask

  function automatic void check_field(string field, logic [31:0] exp_v,
                                      logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // Input driver: take the handshake, then present the next word or a gap
  always @(posedge clk) begin
    drv_valid = in_valid;
    drv_word = in_data;
    if (!rst_n) begin
      drv_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        count_crossings(in_data);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (sample_words.size() > 0) begin
          if (in_idle_on && $urandom_range(0, 3) == 0) begin
            in_gap = pick_gap();
          end else begin
            drv_word = sample_words[0];
            sample_words.delete(0);
            drv_valid = 1'b1;
          end
        end
      end
    end
    in_valid <= drv_valid;
    in_data <= drv_word;
  end

  // Result monitor: check accepted words, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crossing_words_due.size() == 0) begin
        $error("result word arrived with nothing expected");
        n_errors++;
      end else begin
        want = crossing_words_due[0];
        crossing_words_due.delete(0);
        check_field("kind", want.kind, out_data.kind);
        check_field("zero_crossings", want.zero_crossings, out_data.zero_crossings);
        check_field("level_crossings", want.level_crossings, out_data.level_crossings);
        check_field("avg_zero_crossings", want.avg_zero_crossings,
                    out_data.avg_zero_crossings);
        check_field("avg_level_crossings", want.avg_level_crossings,
                    out_data.avg_level_crossings);
        check_field("last", want.last, out_data.last);
      end
    end
    nxt_stall = 1'b0;
    if (out_gap > 0) begin
      out_gap--;
      nxt_stall = 1'b1;
    end else if (rst_n && out_idle_on && $urandom_range(0, 3) == 0) begin
      out_gap = pick_gap() - 1;
      nxt_stall = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_word(int s, bit eos);
    in_word_t w;
    w.sample = SAMPLE_W'(s);
    w.end_of_stream = eos;
    sample_words = {sample_words, w};
  endtask

  // Hold until every word is sent and answered, then let the block settle
  task automatic drain();
    while (sample_words.size() != 0 || in_valid || crossing_words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_LEVEL_THRESHOLD) thresh_q = data[SAMPLE_W-1:0];
    else len_q = data[LEN_W-1:0];
  endtask

  function automatic int clamp_sample(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mix of skipped values, near-threshold wiggle, small bipolar and full range
  function automatic int pick_sample();
    int t;
    t = thresh_q;
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return t;
      2, 3:    return clamp_sample(t + $urandom_range(0, 80) - 40);
      4, 5:    return $urandom_range(0, 600) - 300;
      6:       return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3, 4, 5: return CFG_DATA_W'($urandom_range(0, 1000) - 500);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Mostly short frames; now and then out-of-range or full-size lengths
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0:          len = LEN_W'($urandom_range(0, 1));
      1:          len = $urandom_range(0, 1) ? LEN_MAX : LEN_W'($urandom_range(4097, 8191));
      2, 3, 4:    len = LEN_W'($urandom_range(2, 8));
      default:    len = LEN_W'($urandom_range(9, 64));
    endcase
    return {3'($urandom_range(0, 7)), len};
  endfunction

  initial begin
    int n_sent;
    int n_streams;
    int stream_len;
    int unsigned lim;
    bit eos;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: skipped samples at zero and at the level, extremes
    add_word(0, 0);
    add_word(5, 0);
    add_word(0, 0);
    add_word(-3, 0);
    add_word(1000, 0);
    add_word(2000, 0);
    add_word(1000, 0);
    add_word(999, 0);
    add_word(-32768, 0);
    add_word(32767, 0);
    add_word(32767, 0);
    add_word(1001, 1);
    add_word(-7, 1);
    drain();

    // Lowest level, length below range, frame end together with end of stream
    write_reg(REG_LEVEL_THRESHOLD, 16'h8000);
    write_reg(REG_FRAME_LENGTH, '0);
    add_word(-32768, 0);
    add_word(5, 0);
    add_word(-32768, 0);
    add_word(-32768, 0);
    add_word(32767, 0);
    add_word(-32767, 1);
    drain();

    // Highest level, length above range, then shorten the length mid-frame
    write_reg(REG_LEVEL_THRESHOLD, 16'h7FFF);
    write_reg(REG_FRAME_LENGTH, 16'h1FFF);
    add_word(32767, 0);
    add_word(-1, 0);
    add_word(1, 0);
    add_word(32767, 0);
    add_word(32767, 0);
    drain();
    write_reg(REG_FRAME_LENGTH, 16'd3);
    add_word(-5, 0);
    add_word(4, 0);
    add_word(0, 1);
    drain();

    // Random phases: new settings, random idling, a few streams each
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(REG_LEVEL_THRESHOLD, pick_threshold());
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_LENGTH, pick_length());
      in_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      lim = len_q;
      if (lim < LEN_MIN) lim = LEN_MIN;
      if (lim > LEN_MAX) lim = LEN_MAX;
      n_streams = $urandom_range(1, 4);
      for (int s = 0; s < n_streams; s++) begin
        stream_len = $urandom_range(1, (3 * lim > 150) ? 150 : 3 * lim);
        for (int i = 0; i < stream_len; i++) begin
          eos = (i == stream_len - 1) &&
                (s < n_streams - 1 || $urandom_range(0, 4) != 0);
          add_word(pick_sample(), eos);
        end
        n_sent += stream_len;
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
